// ===== rtl/rsos_pkg.sv =====
`default_nettype none

package rsos_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    // field widths
    localparam int CH_W    = 3;
    localparam int VAL_W   = 32;
    localparam int SCORE_W = 17;
    localparam int CNT_W   = 32;
    localparam int STD_W   = 31;
    localparam int THR_W   = 31;
    localparam int MINS_W  = 16;
    localparam int M2_W    = 64;
    localparam int ITER_W  = 7;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_IDX_THRESHOLD   = 1'b0;
    localparam logic REG_IDX_MIN_SAMPLES = 1'b1;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(196608);
    localparam logic [MINS_W-1:0]  MINS_RESET  = MINS_W'(10);
    localparam logic [SCORE_W-1:0] SCORE_FULL  = SCORE_W'(65536);
    localparam logic [STD_W-1:0]   STD_MAX     = {STD_W{1'b1}};
    localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/rsos_in_if.sv =====
`default_nettype none

interface rsos_in_if;
    import rsos_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     clear_all;
    logic [CH_W-1:0]          channel;
    logic signed [VAL_W-1:0]  sample;

    modport source (output valid, clear_all, channel, sample, input ready);
    modport sink   (input valid, clear_all, channel, sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/rsos_out_if.sv =====
`default_nettype none

interface rsos_out_if;
    import rsos_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic [SCORE_W-1:0]       outlier_score;
    logic [CNT_W-1:0]         sample_count;
    logic signed [VAL_W-1:0]  mean_value;
    logic signed [VAL_W-1:0]  min_value;
    logic signed [VAL_W-1:0]  max_value;
    logic [STD_W-1:0]         std_dev;

    modport source (output valid, out_channel, outlier_score, sample_count, mean_value,
                    min_value, max_value, std_dev, input ready);
    modport sink   (input valid, out_channel, outlier_score, sample_count, mean_value,
                    min_value, max_value, std_dev, output ready);
endinterface

`default_nettype wire

// ===== rtl/running_stats_outlier_scorer_top.sv =====
`default_nettype none

// channel   dir  handshake      word
// in_ch     in   valid/ready    clear_all, channel, sample
// out_ch    out  valid/ready    channel, score, count, mean, min, max, std
// apb       in   psel/penable   outlier_threshold @0x0, min_samples @0x4
//
// one word at a time; a sample word runs its steps on the single shared
// shift-subtract unit: when scored, a 64-step m2/count divide, a 32-step
// sqrt and a 16-step score divide, then a 32-step mean divide, a 64-step
// m2/n divide and a 32-step sqrt; clear and out-of-range words go straight
// to write-out. the output register holds one finished word, so a stalled sink
// holds only the final write-out step; no clearing pass after reset (valid bits)
module running_stats_outlier_scorer_top #(
    parameter int NUM_CHANNELS = rsos_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rsos_in_if.sink                          in_ch,
    rsos_out_if.source                       out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rsos_pkg::APB_AW-1:0] paddr,
    input  wire logic [rsos_pkg::APB_DW-1:0] pwdata,
    output logic      [rsos_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);
    import rsos_pkg::*;

    localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_LOAD  = 17'h00002,
        ST_SDIV  = 17'h00004,
        ST_SSQRT = 17'h00008,
        ST_SMUL  = 17'h00010,
        ST_SCMP  = 17'h00020,
        ST_SCORE = 17'h00040,
        ST_UPD   = 17'h00080,
        ST_UDIV  = 17'h00100,
        ST_UMEAN = 17'h00200,
        ST_UDEL  = 17'h00400,
        ST_UMUL  = 17'h00800,
        ST_UACC  = 17'h01000,
        ST_WB    = 17'h02000,
        ST_RDIV  = 17'h04000,
        ST_RSQRT = 17'h08000,
        ST_OUT   = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [THR_W-1:0]  thr_reg;
    logic [MINS_W-1:0] mins_reg;

    // per-channel statistics
    logic [CNT_W-1:0]        cnt_mem  [NUM_CHANNELS];
    logic signed [VAL_W-1:0] mean_mem [NUM_CHANNELS];
    logic signed [VAL_W-1:0] min_mem  [NUM_CHANNELS];
    logic signed [VAL_W-1:0] max_mem  [NUM_CHANNELS];
    logic [M2_W-1:0]         m2_mem   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;

    logic [CNT_W-1:0]        rd_cnt_reg;
    logic signed [VAL_W-1:0] rd_mean_reg, rd_min_reg, rd_max_reg;
    logic [M2_W-1:0]         rd_m2_reg;
    logic                    rd_vld_reg;

    // working registers
    logic [CH_W-1:0]         ch_reg;
    logic [IdxW-1:0]         idx_reg;
    logic signed [VAL_W-1:0] v_reg, mean_reg, min_reg, max_reg;
    logic [CNT_W-1:0]        cnt_reg, n_reg;
    logic [M2_W-1:0]         m2_reg;
    logic [31:0]             d_reg, d2_reg;
    logic                    neg_reg;
    logic [STD_W-1:0]        sd_reg, std_reg;
    logic [SCORE_W-1:0]      score_reg;

    // shared shift-subtract unit
    logic [63:0]       rem_reg, q_reg, div_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              is_sqrt, ge, last_step;
    logic [64:0]       rem_sh, opa, opb, diff;
    logic [63:0]       rem_step, q_step, div_step;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_reg;

    logic             out_valid_reg;
    logic             in_accept, out_load, cfg_write;
    logic [IdxW-1:0]  in_idx;
    logic             in_range;

    // loaded entry, zero where never written since clear
    logic [CNT_W-1:0]        ld_cnt;
    logic signed [VAL_W-1:0] ld_mean, ld_min, ld_max;
    logic [M2_W-1:0]         ld_m2;
    logic [32:0]             ld_delta, upd_delta;
    logic [CNT_W-1:0]        n_sat;
    logic [63:0]             score_num;
    logic [64:0]             m2_sum;
    logic [STD_W-1:0]        sqrt_sat;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign in_idx      = IdxW'(in_ch.channel);
    assign in_range    = int'(in_ch.channel) < NUM_CHANNELS;
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    assign cfg_write   = psel && penable && pwrite && pready;

    // apb
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            REG_IDX_THRESHOLD:   prdata = APB_DW'(thr_reg);
            REG_IDX_MIN_SAMPLES: prdata = APB_DW'(mins_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            mins_reg <= MINS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_IDX_THRESHOLD:   thr_reg  <= pwdata[THR_W-1:0];
                REG_IDX_MIN_SAMPLES: mins_reg <= pwdata[MINS_W-1:0];
                default:             ;
            endcase
        end
    end

    // shift-subtract step: restoring divide or integer square root
    assign is_sqrt  = (state_reg == ST_SSQRT) || (state_reg == ST_RSQRT);
    assign rem_sh   = {rem_reg, q_reg[63]};
    assign opa      = is_sqrt ? {1'b0, rem_reg} : rem_sh;
    assign opb      = is_sqrt ? {1'b0, q_reg + div_reg} : {1'b0, div_reg};
    assign diff     = opa - opb;
    assign ge       = ~diff[64];
    assign rem_step = ge ? diff[63:0] : (is_sqrt ? rem_reg : rem_sh[63:0]);
    assign q_step   = is_sqrt ? (ge ? (q_reg >> 1) + div_reg : q_reg >> 1)
                              : {q_reg[62:0], ge};
    assign div_step = is_sqrt ? (div_reg >> 2) : div_reg;
    assign last_step = (iter_reg == ITER_W'(1));
    assign sqrt_sat = (q_step > 64'(STD_MAX)) ? STD_MAX : q_step[STD_W-1:0];

    // multiplier: std * threshold, then |delta| * |delta2|
    assign mul_a = (state_reg == ST_SMUL) ? 32'(sd_reg)  : d_reg;
    assign mul_b = (state_reg == ST_SMUL) ? 32'(thr_reg) : d2_reg;

    assign ld_cnt   = rd_vld_reg ? rd_cnt_reg  : '0;
    assign ld_mean  = rd_vld_reg ? rd_mean_reg : '0;
    assign ld_min   = rd_vld_reg ? rd_min_reg  : '0;
    assign ld_max   = rd_vld_reg ? rd_max_reg  : '0;
    assign ld_m2    = rd_vld_reg ? rd_m2_reg   : '0;
    assign ld_delta  = {v_reg[31], v_reg} - {ld_mean[31], ld_mean};
    assign upd_delta = {v_reg[31], v_reg} - {mean_reg[31], mean_reg};
    assign n_sat     = (cnt_reg == COUNT_MAX) ? COUNT_MAX : cnt_reg + CNT_W'(1);
    assign score_num = {16'b0, d_reg, 16'b0};
    assign m2_sum    = {1'b0, m2_reg} + {1'b0, mul_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                    state_next = (in_ch.clear_all || !in_range) ? ST_OUT : ST_LOAD;
            ST_LOAD:  state_next = (ld_cnt > CNT_W'(mins_reg)) ? ST_SDIV : ST_UPD;
            ST_SDIV:  if (last_step) state_next = ST_SSQRT;
            ST_SSQRT: if (last_step) state_next = (sqrt_sat == '0) ? ST_UPD : ST_SMUL;
            ST_SMUL:  state_next = ST_SCMP;
            ST_SCMP:  state_next = (score_num >= mul_reg) ? ST_UPD : ST_SCORE;
            ST_SCORE: if (last_step) state_next = ST_UPD;
            ST_UPD:   state_next = (cnt_reg == '0) ? ST_WB : ST_UDIV;
            ST_UDIV:  if (last_step) state_next = ST_UMEAN;
            ST_UMEAN: state_next = ST_UDEL;
            ST_UDEL:  state_next = ST_UMUL;
            ST_UMUL:  state_next = ST_UACC;
            ST_UACC:  state_next = ST_WB;
            ST_WB:    state_next = ST_RDIV;
            ST_RDIV:  if (last_step) state_next = ST_RSQRT;
            ST_RSQRT: if (last_step) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept && in_ch.clear_all)
                valid_reg <= '0;
            else if (state_reg == ST_WB)
                valid_reg[idx_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // statistics memories, registered read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_cnt_reg  <= cnt_mem[in_idx];
            rd_mean_reg <= mean_mem[in_idx];
            rd_min_reg  <= min_mem[in_idx];
            rd_max_reg  <= max_mem[in_idx];
            rd_m2_reg   <= m2_mem[in_idx];
            rd_vld_reg  <= valid_reg[in_idx];
        end
        if (state_reg == ST_WB)
        begin
            cnt_mem[idx_reg]  <= n_reg;
            mean_mem[idx_reg] <= mean_reg;
            min_mem[idx_reg]  <= min_reg;
            max_mem[idx_reg]  <= max_reg;
            m2_mem[idx_reg]   <= m2_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                begin
                    ch_reg    <= in_ch.channel;
                    idx_reg   <= in_idx;
                    v_reg     <= in_ch.sample;
                    score_reg <= '0;
                    n_reg     <= '0;
                    mean_reg  <= '0;
                    min_reg   <= '0;
                    max_reg   <= '0;
                    std_reg   <= '0;
                end
            ST_LOAD:
            begin
                cnt_reg  <= ld_cnt;
                mean_reg <= ld_mean;
                min_reg  <= ld_min;
                max_reg  <= ld_max;
                m2_reg   <= ld_m2;
                neg_reg  <= ld_delta[32];
                d_reg    <= ld_delta[32] ? 32'(-ld_delta) : ld_delta[31:0];
                rem_reg  <= '0;
                q_reg    <= ld_m2;
                div_reg  <= 64'(ld_cnt);
                iter_reg <= ITER_W'(64);
            end
            ST_SDIV, ST_RDIV:
            begin
                if (last_step)
                begin
                    rem_reg  <= q_step;
                    q_reg    <= '0;
                    div_reg  <= 64'h4000_0000_0000_0000;
                    iter_reg <= ITER_W'(32);
                end
                else
                begin
                    rem_reg  <= rem_step;
                    q_reg    <= q_step;
                    iter_reg <= iter_reg - ITER_W'(1);
                end
            end
            ST_SSQRT, ST_RSQRT, ST_SCORE, ST_UDIV:
            begin
                rem_reg  <= rem_step;
                q_reg    <= q_step;
                div_reg  <= div_step;
                iter_reg <= iter_reg - ITER_W'(1);
                if (last_step)
                begin
                    case (state_reg)
                        ST_SSQRT: sd_reg    <= sqrt_sat;
                        ST_RSQRT: std_reg   <= sqrt_sat;
                        ST_SCORE: score_reg <= {1'b0, q_step[15:0]};
                        default:  d2_reg    <= q_step[31:0];
                    endcase
                end
            end
            ST_SCMP:
            begin
                if (score_num >= mul_reg)
                    score_reg <= SCORE_FULL;
                rem_reg  <= score_num;
                q_reg    <= '0;
                div_reg  <= mul_reg;
                iter_reg <= ITER_W'(16);
            end
            ST_UPD:
            begin
                if (cnt_reg == '0)
                begin
                    mean_reg <= v_reg;
                    min_reg  <= v_reg;
                    max_reg  <= v_reg;
                    m2_reg   <= '0;
                    n_reg    <= CNT_W'(1);
                end
                else
                begin
                    n_reg <= n_sat;
                    if (v_reg < min_reg)
                        min_reg <= v_reg;
                    if (v_reg > max_reg)
                        max_reg <= v_reg;
                end
                rem_reg  <= '0;
                q_reg    <= {d_reg, 32'b0};
                div_reg  <= 64'(n_sat);
                iter_reg <= ITER_W'(32);
            end
            ST_UMEAN:
                mean_reg <= neg_reg ? mean_reg - $signed(d2_reg) : mean_reg + $signed(d2_reg);
            ST_UDEL:
                d2_reg <= upd_delta[32] ? 32'(-upd_delta) : upd_delta[31:0];
            ST_UACC:
                m2_reg <= m2_sum[64] ? {M2_W{1'b1}} : m2_sum[63:0];
            ST_WB:
            begin
                rem_reg  <= '0;
                q_reg    <= m2_reg;
                div_reg  <= 64'(n_reg);
                iter_reg <= ITER_W'(64);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.out_channel   <= ch_reg;
            out_ch.outlier_score <= score_reg;
            out_ch.sample_count  <= n_reg;
            out_ch.mean_value    <= mean_reg;
            out_ch.min_value     <= min_reg;
            out_ch.max_value     <= max_reg;
            out_ch.std_dev       <= std_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

    // a clear word empties every channel
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_ch.clear_all |=> valid_reg == '0)
        else $error("clear left a channel valid");

    // a finished word waits in write-out while the output register is stalled
    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && out_valid_reg && !out_ch.ready |=> state_reg == ST_OUT)
        else $error("result overwrote a stalled word");

    // score never exceeds full scale
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.outlier_score <= SCORE_FULL)
        else $error("score above full scale");

    // one word in flight at a time
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("second word taken while busy");

endmodule

`default_nettype wire
